// File: hdl/motion_state_hysteresis_estimator_assert.svh
// Assertion macros for the motion state estimator.
`ifndef MOTION_STATE_HYSTERESIS_ESTIMATOR_ASSERT_SVH
`define MOTION_STATE_HYSTERESIS_ESTIMATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MSHE_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define MSHE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// File: hdl/mshe_pkg.sv
// Shared types and constants for the motion state estimator.
package mshe_pkg;
  localparam int unsigned TS_W = 48;
  localparam int unsigned POS_W = 32;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] CONF_MIN = 17'd13107;
  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ENTER_SPEED = 3'd1;
  localparam logic [2:0] REG_EXIT_SPEED = 3'd2;
  localparam logic [2:0] REG_ENTER_TIME = 3'd3;
  localparam logic [2:0] REG_EXIT_TIME = 3'd4;
  localparam logic [2:0] REG_MAX_GAP = 3'd5;
  localparam logic [2:0] REG_GAIN = 3'd6;

  localparam logic [3:0] RSN_DISABLED = 4'd0;
  localparam logic [3:0] RSN_BAD_TIME = 4'd1;
  localparam logic [3:0] RSN_ROLLBACK = 4'd2;
  localparam logic [3:0] RSN_EXTERNAL = 4'd3;
  localparam logic [3:0] RSN_HOLD = 4'd4;
  localparam logic [3:0] RSN_UNAVAIL = 4'd5;
  localparam logic [3:0] RSN_BASELINE = 4'd6;
  localparam logic [3:0] RSN_BAD_DT = 4'd7;
  localparam logic [3:0] RSN_ESTIMATE = 4'd8;

  localparam logic [1:0] MS_UNKNOWN = 2'd0;
  localparam logic [1:0] MS_MOVING = 2'd1;
  localparam logic [1:0] MS_SETTLE = 2'd2;
  localparam logic [1:0] MS_STATIONARY = 2'd3;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_EXT = 2'd1;
  localparam logic [1:0] SRC_POS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_MUL, ST_DIV, ST_FILT1, ST_FILT2, ST_CONF,
    ST_DECIDE, ST_OUT
  } ctl_state_t;

  // request and reply between the controller and the serial arithmetic unit
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } ser_req_t;

  typedef struct packed {
    logic done;
  } ser_rsp_t;

  localparam logic [1:0] OP_SQRT = 2'd0;
  localparam logic [1:0] OP_DIV_SPEED = 2'd1;
  localparam logic [1:0] OP_DIV_CONF = 2'd2;
endpackage

// File: hdl/mshe_serial_unit.sv
// Bit-serial square root and restoring divider.
module mshe_serial_unit (
  input  logic                clk,
  input  logic                rst,
  input  mshe_pkg::ser_req_t  req,
  output mshe_pkg::ser_rsp_t  rsp,
  input  logic [65:0]         rad,
  input  logic [67:0]         num,
  input  logic [47:0]         den,
  output logic [67:0]         quo
);
  import mshe_pkg::*;

  logic        busy;
  logic [1:0]  op;
  logic [6:0]  cnt;
  logic [65:0] rad_sh;
  logic [35:0] rem_sq;
  logic [33:0] root;
  logic [67:0] num_sh;
  logic [48:0] rem_dv;
  logic [47:0] den_r;
  logic [35:0] sq_trial;
  logic [35:0] sq_sub;
  logic [48:0] dv_trial;

  // one root bit per cycle: two radicand bits shift into the remainder
  always_comb begin
    sq_trial = {rem_sq[33:0], rad_sh[65:64]};
    sq_sub = {root, 2'b01};
    dv_trial = {rem_dv[47:0], num_sh[67]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        // 33 digit pairs for the root, 68 quotient bits for a divide
        cnt <= (req.op == OP_SQRT) ? 7'd32 : 7'd67;
        rad_sh <= rad;
        rem_sq <= '0;
        root <= '0;
        num_sh <= num;
        rem_dv <= '0;
        den_r <= den;
      end else if (busy) begin
        if (op == OP_SQRT) begin
          rad_sh <= {rad_sh[63:0], 2'b00};
          if (sq_trial >= sq_sub) begin
            rem_sq <= sq_trial - sq_sub;
            root <= {root[32:0], 1'b1};
          end else begin
            rem_sq <= sq_trial;
            root <= {root[32:0], 1'b0};
          end
        end else begin
          if (dv_trial >= {1'b0, den_r}) begin
            rem_dv <= dv_trial - {1'b0, den_r};
            num_sh <= {num_sh[66:0], 1'b1};
          end else begin
            rem_dv <= dv_trial;
            num_sh <= {num_sh[66:0], 1'b0};
          end
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  assign quo = (op == OP_SQRT) ? {34'd0, root} : num_sh;
endmodule

// File: hdl/motion_state_hysteresis_estimator.sv
// Top level of the motion state estimator with hysteresis.
// Input channel s_axis_*: one transfer per sample. tdata packs timestamp, ext_state_valid,
// ext_state, pos_valid, pos_x, pos_y, pos_z from bit 0 up (148 bits, padded to 152).
// Output channel m_axis_*: one result per sample. tdata packs est_valid, motion_state,
// source, confidence, smoothed_speed, state_duration, reason, epoch; tuser is gap_reset.
// Config channel cfg_*: register index and data, taken any time the block is idle.
// Sequence: samples decided without a speed estimate skip the arithmetic. A position
// estimate runs the squares through one multiplier, a serial square root, a
// multiply, a serial speed divide, the filter, a serial confidence divide (skipped
// when dt reaches max_gap_time) and a decision step; the square root and both
// divides share one bit-serial unit. One item is in flight at a time.
// Reset clears the kinematic state and restores the register defaults. When the receiver
// stalls the result waits in the output register; a new sample is taken only after
// the held result is transferred.
module motion_state_hysteresis_estimator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // timestamp, ext_state_valid, ext_state, pos_valid, pos_x, pos_y, pos_z
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // est_valid, motion_state, source, confidence, smoothed_speed, state_duration,
  // reason, epoch
  output logic [127:0] m_axis_tdata,
  // gap_reset
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import mshe_pkg::*;

  // configuration
  logic        enable;
  logic [15:0] enter_still_speed, exit_still_speed;
  logic [47:0] enter_confirm_time, exit_confirm_time, max_gap_time;
  logic [16:0] smoothing_gain;

  // kinematic state
  logic [1:0]  cur_state, cur_source;
  logic        cur_valid, filt_speed_valid, prev_pos_valid;
  logic [16:0] cur_confidence;
  logic [47:0] cur_duration;
  logic [15:0] filt_speed;
  logic [31:0] epoch_count;
  logic [47:0] last_time, last_sample_time, state_start_time, candidate_start_time;
  logic [31:0] prev_pos [3];

  // working registers
  ctl_state_t  state, state_next;
  logic [47:0] ts, dt;
  logic [31:0] new_pos [3];
  logic [31:0] d_abs [3];
  logic [1:0]  sq_idx;
  logic [65:0] sum_sq;
  logic [63:0] prod;
  logic [15:0] speed;
  logic [32:0] filt_a, filt_b;
  logic [3:0]  reason;
  logic        gap;

  logic [31:0] in_pos [3];
  logic        s_fire, m_fire, cfg_fire;
  ser_req_t    sreq;
  ser_rsp_t    srsp;
  logic [65:0] s_rad;
  logic [67:0] s_num;
  logic [47:0] s_den;
  logic [67:0] s_quo;
  logic [31:0] sq_op;
  logic [63:0] sq_prod;

  assign in_pos[0] = s_axis_tdata[83:52];
  assign in_pos[1] = s_axis_tdata[115:84];
  assign in_pos[2] = s_axis_tdata[147:116];

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_fire = cfg_valid && cfg_ready;

  mshe_serial_unit u_ser (
    .clk(clk), .rst(rst), .req(sreq), .rsp(srsp),
    .rad(s_rad), .num(s_num), .den(s_den), .quo(s_quo)
  );

  assign s_rad = sum_sq;

  // one axis square per cycle
  always_comb begin
    case (sq_idx)
      2'd1:    sq_op = d_abs[1];
      2'd2:    sq_op = d_abs[2];
      default: sq_op = d_abs[0];
    endcase
    sq_prod = sq_op * sq_op;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   state_next = ST_IDLE;
      ST_SQ:     if (sq_idx == 2'd3) state_next = ST_SQRT;
      ST_SQRT:   if (srsp.done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (srsp.done) state_next = ST_FILT1;
      ST_FILT1:  state_next = ST_FILT2;
      ST_FILT2:  state_next = (dt >= max_gap_time) ? ST_DECIDE : ST_CONF;
      ST_CONF:   if (srsp.done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // serial unit requests
  always_comb begin
    sreq.start = 1'b0;
    sreq.op = OP_SQRT;
    s_num = {4'd0, prod};
    s_den = dt;
    unique case (state)
      ST_SQ: begin
        sreq.start = (sq_idx == 2'd3);
        sreq.op = OP_SQRT;
      end
      ST_MUL: begin
        sreq.start = 1'b1;
        sreq.op = OP_DIV_SPEED;
      end
      ST_FILT2: begin
        sreq.start = !(dt >= max_gap_time);
        sreq.op = OP_DIV_CONF;
        s_num = {4'd0, dt, 16'd0};
        s_den = max_gap_time;
      end
      ST_CONF: begin
        sreq.op = OP_DIV_CONF;
        s_num = {4'd0, dt, 16'd0};
        s_den = max_gap_time;
      end
      default: ;
    endcase
  end

  // hysteresis decision on the filtered speed
  logic [1:0]  dec_state;
  logic [47:0] dec_start, dec_cand;
  logic [47:0] cand_tmp;
  always_comb begin
    dec_state = cur_state;
    dec_start = state_start_time;
    dec_cand = candidate_start_time;
    cand_tmp = (candidate_start_time == '0) ? ts : candidate_start_time;
    unique case (cur_state)
      MS_UNKNOWN: begin
        if (filt_speed >= exit_still_speed) dec_state = MS_MOVING;
        else begin
          dec_state = MS_SETTLE;
          dec_cand = ts;
        end
      end
      MS_MOVING: begin
        if (filt_speed <= enter_still_speed) begin
          dec_state = MS_SETTLE;
          dec_cand = ts;
        end
      end
      MS_SETTLE: begin
        if (filt_speed >= exit_still_speed) begin
          dec_state = MS_MOVING;
          dec_cand = '0;
        end else if (filt_speed <= enter_still_speed) begin
          dec_cand = cand_tmp;
          if (ts - cand_tmp >= enter_confirm_time) begin
            dec_state = MS_STATIONARY;
            dec_cand = '0;
          end
        end else dec_cand = ts;
      end
      default: begin
        if (filt_speed >= exit_still_speed) begin
          dec_cand = cand_tmp;
          if (ts - cand_tmp >= exit_confirm_time) begin
            dec_state = MS_MOVING;
            dec_cand = '0;
          end
        end else dec_cand = '0;
      end
    endcase
    if (dec_state != cur_state || state_start_time == '0) dec_start = ts;
  end

  logic [47:0] in_ts;
  logic [47:0] ext_start;
  assign in_ts = s_axis_tdata[47:0];
  assign ext_start = (cur_state != s_axis_tdata[50:49] || state_start_time == '0) ?
                     in_ts : state_start_time;

  logic [16:0] g_sat;
  assign g_sat = (smoothing_gain > ONE_Q16) ? ONE_Q16 : smoothing_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      enable <= 1'b1;
      enter_still_speed <= 16'd50;
      exit_still_speed <= 16'd100;
      enter_confirm_time <= 48'd500000;
      exit_confirm_time <= 48'd100000;
      max_gap_time <= 48'd500000;
      smoothing_gain <= 17'd19661;
      cur_state <= MS_UNKNOWN; cur_valid <= 1'b0; cur_source <= SRC_NONE;
      cur_confidence <= '0; cur_duration <= '0; filt_speed <= '0;
      filt_speed_valid <= 1'b0; epoch_count <= '0; last_time <= '0;
      last_sample_time <= '0; state_start_time <= '0; candidate_start_time <= '0;
      prev_pos_valid <= 1'b0;
      for (int i = 0; i < 3; i++) prev_pos[i] <= '0;
      sq_idx <= '0;
      gap <= 1'b0;
      reason <= RSN_DISABLED;
    end else begin
      if (!s_fire) state <= state_next;
      if (m_fire) m_axis_tvalid <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_ENABLE:      enable <= cfg_data[0];
          REG_ENTER_SPEED: enter_still_speed <= cfg_data[15:0];
          REG_EXIT_SPEED:  exit_still_speed <= cfg_data[15:0];
          REG_ENTER_TIME:  enter_confirm_time <= cfg_data;
          REG_EXIT_TIME:   exit_confirm_time <= cfg_data;
          REG_MAX_GAP:     max_gap_time <= cfg_data;
          REG_GAIN:        smoothing_gain <= cfg_data[16:0];
          default: ;
        endcase
      end

      if (s_fire) begin
        logic g;
        logic [47:0] sst;
        g = 1'b0;
        sst = last_sample_time;
        ts <= in_ts;
        for (int i = 0; i < 3; i++) new_pos[i] <= in_pos[i];
        if (!enable) begin
          cur_state <= MS_UNKNOWN; cur_valid <= 1'b0; cur_source <= SRC_NONE;
          cur_confidence <= '0; cur_duration <= '0; filt_speed <= '0;
          filt_speed_valid <= 1'b0; epoch_count <= '0; last_time <= '0;
          last_sample_time <= '0; state_start_time <= '0; candidate_start_time <= '0;
          prev_pos_valid <= 1'b0;
          for (int i = 0; i < 3; i++) prev_pos[i] <= '0;
          reason <= RSN_DISABLED; gap <= 1'b0;
          state <= ST_OUT; m_axis_tvalid <= 1'b1;
        end else if (in_ts == '0) begin
          cur_valid <= 1'b0;
          reason <= RSN_BAD_TIME; gap <= 1'b0;
          state <= ST_OUT; m_axis_tvalid <= 1'b1;
        end else if (last_time != '0 && in_ts <= last_time) begin
          cur_state <= MS_UNKNOWN; cur_valid <= 1'b0; cur_source <= SRC_NONE;
          cur_confidence <= '0; cur_duration <= '0; filt_speed <= '0;
          filt_speed_valid <= 1'b0; epoch_count <= epoch_count + 32'd1;
          last_time <= in_ts;
          last_sample_time <= '0; state_start_time <= '0; candidate_start_time <= '0;
          prev_pos_valid <= 1'b0;
          for (int i = 0; i < 3; i++) prev_pos[i] <= '0;
          reason <= RSN_ROLLBACK; gap <= 1'b0;
          state <= ST_OUT; m_axis_tvalid <= 1'b1;
        end else begin
          logic [1:0] cs, csrc;
          logic [47:0] sstart, cand, cdur;
          logic ppv, fsv, cv;
          logic [16:0] cconf;
          logic [15:0] fspd;
          logic [31:0] pp [3];
          cs = cur_state; csrc = cur_source; sstart = state_start_time;
          cand = candidate_start_time; cdur = cur_duration; ppv = prev_pos_valid;
          fsv = filt_speed_valid; cv = cur_valid; cconf = cur_confidence;
          fspd = filt_speed;
          for (int i = 0; i < 3; i++) pp[i] = prev_pos[i];
          // long gap: start over from the reset state, then handle the sample
          if (last_time != '0 && in_ts - last_time > max_gap_time) begin
            g = 1'b1;
            cs = MS_UNKNOWN; csrc = SRC_NONE; sstart = '0; cand = '0; cdur = '0;
            ppv = 1'b0; fsv = 1'b0; cv = 1'b0; cconf = '0; fspd = '0; sst = '0;
            for (int i = 0; i < 3; i++) pp[i] = '0;
          end
          gap <= g;
          last_time <= in_ts;
          if (s_axis_tdata[48] && s_axis_tdata[50:49] != MS_UNKNOWN) begin
            if (cs != s_axis_tdata[50:49] || sstart == '0) sstart = in_ts;
            cs = s_axis_tdata[50:49];
            cv = 1'b1; csrc = SRC_EXT; cconf = ONE_Q16;
            cdur = in_ts - sstart;
            sst = in_ts; cand = '0;
            reason <= RSN_EXTERNAL;
            state <= ST_OUT; m_axis_tvalid <= 1'b1;
          end else if (!s_axis_tdata[51]) begin
            logic hold;
            hold = sst != '0 && in_ts >= sst && in_ts - sst <= max_gap_time &&
                   cs != MS_UNKNOWN;
            cv = hold;
            reason <= hold ? RSN_HOLD : RSN_UNAVAIL;
            state <= ST_OUT; m_axis_tvalid <= 1'b1;
          end else if (!ppv) begin
            for (int i = 0; i < 3; i++) pp[i] = in_pos[i];
            ppv = 1'b1; sst = in_ts;
            cv = 1'b0; csrc = SRC_POS;
            reason <= RSN_BASELINE;
            state <= ST_OUT; m_axis_tvalid <= 1'b1;
          end else if (in_ts <= sst || in_ts - sst <= 48'd1) begin
            cv = 1'b0;
            reason <= RSN_BAD_DT;
            state <= ST_OUT; m_axis_tvalid <= 1'b1;
          end else begin
            dt <= in_ts - sst;
            for (int i = 0; i < 3; i++) begin
              logic [32:0] df;
              df = {in_pos[i][31], in_pos[i]} - {pp[i][31], pp[i]};
              d_abs[i] <= df[32] ? 32'(-df) : df[31:0];
            end
            sum_sq <= '0; sq_idx <= '0;
            reason <= RSN_ESTIMATE;
            state <= ST_SQ;
          end
          cur_state <= cs; cur_source <= csrc; state_start_time <= sstart;
          candidate_start_time <= cand; cur_duration <= cdur;
          prev_pos_valid <= ppv; filt_speed_valid <= fsv; cur_valid <= cv;
          cur_confidence <= cconf; filt_speed <= fspd; last_sample_time <= sst;
          for (int i = 0; i < 3; i++) prev_pos[i] <= pp[i];
        end
      end

      unique case (state)
        ST_SQ: begin
          if (sq_idx != 2'd3) begin
            sum_sq <= sum_sq + {2'b00, sq_prod};
            sq_idx <= sq_idx + 2'd1;
          end
        end
        ST_SQRT: if (srsp.done) prod <= s_quo[33:0] * US_PER_S;
        ST_DIV: if (srsp.done) begin
          speed <= (s_quo[67:16] != '0) ? 16'hFFFF : s_quo[15:0];
          for (int i = 0; i < 3; i++) prev_pos[i] <= new_pos[i];
          last_sample_time <= ts;
        end
        ST_FILT1: begin
          filt_a <= (ONE_Q16 - g_sat) * filt_speed;
          filt_b <= g_sat * speed;
        end
        ST_FILT2: begin
          if (!filt_speed_valid || (g_sat == ONE_Q16)) filt_speed <= speed;
          else filt_speed <= 16'((filt_a + filt_b + 33'd32768) >> 16);
          filt_speed_valid <= 1'b1;
          cur_source <= SRC_POS;
          if (dt >= max_gap_time) cur_confidence <= ONE_Q16;
        end
        ST_CONF: if (srsp.done) cur_confidence <= (s_quo[16:0] < CONF_MIN) ? CONF_MIN :
                                                  s_quo[16:0];
        ST_DECIDE: begin
          cur_state <= dec_state;
          state_start_time <= dec_start;
          candidate_start_time <= dec_cand;
          cur_valid <= dec_state != MS_UNKNOWN;
          cur_duration <= ts - dec_start;
          m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {6'b0, epoch_count, reason, cur_duration, filt_speed,
                         cur_confidence, cur_source, cur_state, cur_valid};
  assign m_axis_tuser = gap;

  logic unused_ok;
  assign unused_ok = ^{ext_start, s_axis_tdata[151:148]};

  `include "motion_state_hysteresis_estimator_assert.svh"
  `MSHE_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !s_axis_tready)
  `MSHE_ASSERT_NEXT(a_decide_emits, clk, rst, state == ST_DECIDE, m_axis_tvalid)
  `MSHE_ASSERT_IMP(a_conf_range, clk, rst, m_axis_tvalid && reason == RSN_ESTIMATE,
                   cur_confidence >= CONF_MIN)
endmodule
